// File: design/psd_pkg.sv
package psd_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 8;

  localparam logic       KIND_ENQ  = 1'b0;
  localparam logic       KIND_DISP = 1'b1;

  localparam logic       PASS_STACK = 1'b0;
  localparam logic       PASS_QUEUE = 1'b1;

  localparam logic [PRIO_W-1:0] THRESH_RESET = 8'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } psd_state_t;

endpackage

// File: design/priority_split_dispatcher_top.sv
// Priority split dispatcher.
// in_* carries beats of two kinds (in_tuser): enqueue appends the id and
// priority in in_tdata to a store of QUEUE_DEPTH entries, or drops it when
// the store is full; dispatch drains the store. A dispatch first returns,
// newest first, every entry whose priority is at or above the threshold
// (out_tuser = 1), then the rest oldest first (out_tuser = 0). out_tlast
// marks the final beat; an empty store gives no beats.
// cfg_* writes the 8-bit threshold; cfg_ready is always high.
// An enqueue is taken while in_tready stays high. A dispatch visits each
// entry twice through one memory port and one comparator, a read state and
// a compare state per visit, and pauses for any out_tready stall. in_tready
// is low for the whole dispatch. Each result is held in a staging register
// until the next match or the flush, so that last can be marked.
// When the receiver stalls, the output register holds its beat and the walk
// pauses at the next match. Reset (rst_n low, synchronous) empties the
// store, drops any pending output and sets the threshold to 5.
module priority_split_dispatcher_top #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // [15:0] process_id, [23:16] priority_req
  input  logic                       in_tuser,   // kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,  // [15:0] process_id_res
  output logic                       out_tuser,  // from_stack
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [psd_pkg::PRIO_W-1:0] cfg_data
);
  import psd_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  psd_state_t state_r, state_nxt;

  logic [ID_W-1:0]   mem_id   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] mem_prio [QUEUE_DEPTH];

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              pass_r, pass_nxt;
  logic [PRIO_W-1:0] thr_r;
  logic [ID_W-1:0]   rd_id_r;
  logic [PRIO_W-1:0] rd_prio_r;

  logic              hold_vld_r, hold_vld_nxt;
  logic [ID_W-1:0]   hold_id_r;
  logic              hold_stk_r;

  logic              out_vld_r, out_vld_nxt;
  logic [ID_W-1:0]   out_id_r;
  logic              out_stk_r;
  logic              out_last_r;

  logic              in_fire, is_enq, is_disp, full, out_free;
  logic              wr_en, rd_en, match, eval_go;
  logic              load_hold, push_hold, push_last;
  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     last_idx;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_stk_r;
  assign out_tlast  = out_last_r;

  assign in_fire  = in_tvalid && in_tready;
  assign is_enq   = in_fire && (in_tuser == KIND_ENQ);
  assign is_disp  = in_fire && (in_tuser == KIND_DISP);
  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign out_free = !out_vld_r || out_tready;
  assign wr_en    = is_enq && !full;
  assign cnt_m1   = cnt_r - 1'b1;
  assign last_idx = cnt_m1[AW-1:0];

  // Shared comparator: stack pass takes >= threshold, queue pass the rest.
  assign match   = (rd_prio_r >= thr_r) ^ (pass_r == PASS_QUEUE);
  // A match must move the staged beat out first, so wait for a free slot.
  assign eval_go = !(match && hold_vld_r && !out_free);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_disp && (cnt_r != '0)) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (eval_go) begin
          if ((pass_r == PASS_QUEUE) && (idx_r == last_idx)) state_nxt = ST_FLUSH;
          else                                               state_nxt = ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!hold_vld_r || out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    rd_en     = 1'b0;
    load_hold = 1'b0;
    push_hold = 1'b0;
    push_last = 1'b0;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (wr_en) cnt_nxt = cnt_r + 1'b1;
        if (is_disp) begin
          idx_nxt  = last_idx;
          pass_nxt = PASS_STACK;
        end
      end
      ST_READ: rd_en = 1'b1;
      ST_EVAL: begin
        if (eval_go) begin
          load_hold = match;
          push_hold = match && hold_vld_r;
          if (pass_r == PASS_STACK) begin
            if (idx_r == '0) pass_nxt = PASS_QUEUE;
            else             idx_nxt  = idx_r - 1'b1;
          end else if (idx_r != last_idx) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_vld_r || out_free) begin
          push_hold = hold_vld_r;
          push_last = hold_vld_r;
          cnt_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (load_hold)      hold_vld_nxt = 1'b1;
    else if (push_hold) hold_vld_nxt = 1'b0;

    out_vld_nxt = out_vld_r;
    if (push_hold)       out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      idx_r      <= '0;
      pass_r     <= PASS_STACK;
      thr_r      <= THRESH_RESET;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      idx_r      <= idx_nxt;
      pass_r     <= pass_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_valid && cfg_ready) thr_r <= cfg_data;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load_hold) begin
      hold_id_r  <= rd_id_r;
      hold_stk_r <= (pass_r == PASS_STACK);
    end
    if (push_hold) begin
      out_id_r   <= hold_id_r;
      out_stk_r  <= hold_stk_r;
      out_last_r <= push_last;
    end
  end

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[cnt_r[AW-1:0]]   <= in_tdata[ID_W-1:0];
      mem_prio[cnt_r[AW-1:0]] <= in_tdata[ID_W +: PRIO_W];
    end
    if (rd_en) begin
      rd_id_r   <= mem_id[idx_r];
      rd_prio_r <= mem_prio[idx_r];
    end
  end

endmodule

// File: design/psd_checker.sv
module psd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed under stall");

  // A dispatch finishes only by presenting its last beat.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) |-> out_tvalid && out_tlast)
    else $error("dispatch ended without a last beat");

  // While a non-last beat is out, the dispatch is still running.
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input accepted in the middle of a dispatch");

  // Taking a non-last beat leaves the walk running or the last beat on the bus.
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready || (out_tvalid && out_tlast))
    else $error("dispatch ended after a non-last beat");

endmodule

bind priority_split_dispatcher_top psd_checker u_psd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/tb_priority_split_dispatcher_top.sv
module tb_priority_split_dispatcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  localparam int unsigned DEPTH          = 64;
  localparam int unsigned SETTLE_CYCLES  = 4 * DEPTH + 16;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int          FROM_MODEL     = -1;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } proc_entry_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            from_stack;
    logic            last;
  } run_beat_t;

  // typed_n: FROM_MODEL = predicted, 0 = no beats, 1 = the single beat given
  typedef struct {
    logic              kind;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    int                typed_n;
    logic [ID_W-1:0]   t_id;
    logic              t_stack;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [23:0]       in_tdata;   // [15:0] process_id, [23:16] priority_req
  logic              in_tuser;   // kind
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // [15:0] process_id_res
  logic              out_tuser;  // from_stack
  logic              out_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [PRIO_W-1:0] cfg_data;

  priority_split_dispatcher_top #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // dispatcher mirror
  proc_entry_t       pending_procs[$];
  logic [PRIO_W-1:0] threshold_q;
  run_beat_t         fresh_beats[$];
  run_beat_t         expected_beats[$];

  // what the beat currently offered expects, when typed in by hand
  int                cur_typed_n = FROM_MODEL;
  logic [ID_W-1:0]   cur_t_id = '0;
  logic              cur_t_stack = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_requested = 0;
  int holds_done = 0;
  int hold_left = 0;

  int mismatches = 0;
  int n_enq = 0;
  int n_dropped = 0;
  int n_disp = 0;
  int n_stack_beats = 0;
  int n_queue_beats = 0;
  int quiet_cycles = 0;

  directed_row_t directed_rows[21] = '{
    '{KIND_DISP, 16'h0000, 8'h00, 0,          16'h0000, 1'b0},
    '{KIND_ENQ,  16'hFFFF, 8'h05, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_DISP, 16'h1111, 8'hFF, 1,          16'hFFFF, 1'b1},
    '{KIND_ENQ,  16'h0000, 8'h04, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_DISP, 16'hFFFF, 8'h00, 1,          16'h0000, 1'b0},
    '{KIND_ENQ,  16'h0000, 8'hFF, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_DISP, 16'h0000, 8'h00, 1,          16'h0000, 1'b1},
    '{KIND_ENQ,  16'hFFFF, 8'h00, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_DISP, 16'h0000, 8'h00, 1,          16'hFFFF, 1'b0},
    '{KIND_ENQ,  16'h1234, 8'h00, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_ENQ,  16'hABCD, 8'hFF, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_ENQ,  16'h5555, 8'hC8, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_ENQ,  16'h0001, 8'h06, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_ENQ,  16'h8000, 8'h03, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_ENQ,  16'h7FFF, 8'h05, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_ENQ,  16'hAAAA, 8'h04, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_DISP, 16'h5A5A, 8'hA5, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_DISP, 16'h0000, 8'h00, 0,          16'h0000, 1'b0},
    '{KIND_ENQ,  16'h00FF, 8'h80, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_ENQ,  16'hFF00, 8'h7F, FROM_MODEL, 16'h0000, 1'b0},
    '{KIND_DISP, 16'h0000, 8'h00, FROM_MODEL, 16'h0000, 1'b0}
  };

  // enqueue appends; dispatch drains high priorities newest first, then the rest in order
  function automatic void predict_dispatch(input logic kind, input logic [ID_W-1:0] id,
                                           input logic [PRIO_W-1:0] prio);
    run_beat_t beat;
    fresh_beats.delete();
    if (kind == KIND_ENQ) begin
      n_enq++;
      if (pending_procs.size() < DEPTH) begin
        pending_procs.push_back('{id: id, prio: prio});
      end else begin
        n_dropped++;
      end
    end else begin
      n_disp++;
      for (int i = pending_procs.size() - 1; i >= 0; i--) begin
        if (pending_procs[i].prio >= threshold_q) begin
          beat = '{id: pending_procs[i].id, from_stack: 1'b1, last: 1'b0};
          fresh_beats.push_back(beat);
        end
      end
      foreach (pending_procs[i]) begin
        if (pending_procs[i].prio < threshold_q) begin
          beat = '{id: pending_procs[i].id, from_stack: 1'b0, last: 1'b0};
          fresh_beats.push_back(beat);
        end
      end
      if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size() - 1].last = 1'b1;
      pending_procs.delete();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_beat();
    run_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("beat with nothing outstanding, id", out_tdata, 16'h0);
    end else begin
      want = expected_beats.pop_front();
      if (out_tdata !== want.id) report_mismatch("process id", out_tdata, want.id);
      if (out_tuser !== want.from_stack)
        report_mismatch("from_stack", {15'h0, out_tuser}, {15'h0, want.from_stack});
      if (out_tlast !== want.last)
        report_mismatch("last", {15'h0, out_tlast}, {15'h0, want.last});
      if (want.from_stack) n_stack_beats++;
      else n_queue_beats++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_procs.delete();
      threshold_q = THRESH_RESET;
    end else begin
      if (out_tvalid && out_tready) check_beat();
      if (cfg_valid && cfg_ready) threshold_q = cfg_data;
      if (in_tvalid && in_tready) begin
        predict_dispatch(in_tuser, in_tdata[15:0], in_tdata[23:16]);
        if (cur_typed_n == FROM_MODEL) begin
          foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
        end else if (cur_typed_n == 1) begin
          expected_beats.push_back('{id: cur_t_id, from_stack: cur_t_stack, last: 1'b1});
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_beats.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_requested) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio, input int typed_n,
                           input logic [ID_W-1:0] t_id, input logic t_stack);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    cur_typed_n = typed_n;
    cur_t_id    = t_id;
    cur_t_stack = t_stack;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {prio, id};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // drop valid, let all results come out and the walk finish
  task automatic settle();
    @(negedge clk) in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [PRIO_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // hit the threshold edges often
  function automatic logic [PRIO_W-1:0] pick_priority();
    case ($urandom_range(3))
      0:       return threshold_q - 8'd1;
      1:       return threshold_q;
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n_items);
    int sent;
    int burst;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 8) burst = 0;
      else if (r < 12) burst = $urandom_range(40, 70);
      else burst = $urandom_range(1, 10);
      repeat (burst) send_item(KIND_ENQ, ID_W'($urandom), pick_priority(), FROM_MODEL, '0, 1'b0);
      send_item(KIND_DISP, ID_W'($urandom), PRIO_W'($urandom), FROM_MODEL, '0, 1'b0);
      sent += burst + 1;
      if ($urandom_range(9) == 0) begin
        @(negedge clk) in_tvalid <= 1'b0;
        wait_drained();
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_ENQ;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].kind, directed_rows[i].id, directed_rows[i].prio,
                directed_rows[i].typed_n, directed_rows[i].t_id, directed_rows[i].t_stack);
    end

    write_threshold(8'd0);
    send_idle_pct = 78;
    run_random(24);

    write_threshold(8'd255);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    run_random(24);

    write_threshold(8'd200);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    run_random(24);

    write_threshold(PRIO_W'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(24);

    // fill past capacity while the receiver holds off, so the input backs up
    write_threshold(8'd1);
    holds_requested++;
    repeat (70) send_item(KIND_ENQ, ID_W'($urandom), pick_priority(), FROM_MODEL, '0, 1'b0);
    send_item(KIND_DISP, '0, '0, FROM_MODEL, '0, 1'b0);
    repeat (4) send_item(KIND_ENQ, ID_W'($urandom), pick_priority(), FROM_MODEL, '0, 1'b0);
    send_item(KIND_DISP, '0, '0, FROM_MODEL, '0, 1'b0);
    @(negedge clk) in_tvalid <= 1'b0;
    wait_drained();
    run_random(20);

    write_threshold(8'd128);
    recv_stall_pct = 78;
    run_random(24);

    write_threshold(PRIO_W'($urandom));
    send_idle_pct = 29;
    recv_stall_pct = 29;
    run_random(24);

    settle();
    $display("run covered %0d enqueues (%0d dropped on a full store) and %0d dispatches",
             n_enq, n_dropped, n_disp);
    $display("checked %0d stack-order and %0d queue-order beats over 8 threshold settings",
             n_stack_beats, n_queue_beats);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
